/* design/cdq_pkg.sv */
// Package for the circular deque: sizes, operation and status codes,
// and the control state type. No dependencies.
`default_nettype none

package cdq_pkg;

  // Store geometry
  localparam int DEPTH  = 8;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 4;

  // Operation codes carried by a request transaction
  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control sequencer
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

`default_nettype wire

/* design/cdq_if.sv */
// Valid/ready channel interfaces for the deque request and response.
// Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if
  import cdq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic signed [31:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface cdq_rsp_if
  import cdq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] pop_value;
  logic [3:0]         occupancy;

  modport source (output valid, output status, output pop_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* design/cdq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/circular_deque.sv */
// Circular deque of signed 32-bit words held in a one-port-read RAM.
// A push or a faulted operation is registered straight into the response;
// a successful pop reads the RAM first, then loads the response in S_READ.
// Pushes and faults go one per cycle while the response is free or taken;
// a pop holds off new requests in S_READ. Reset clears head, tail, count and
// response valid; the store is not cleared, as only written slots are read.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  // Pointer and control registers
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  state_t           state, state_next;

  // Response register
  logic               out_valid;
  status_t            out_status;
  logic signed [31:0] out_pop_value;
  logic [OCC_W-1:0]   out_occupancy;

  // RAM access
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  rd_data;
  status_t            status_v;
  logic               accept;
  logic               full;
  logic               empty;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.push_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Handshake: one transaction in flight, output slot must be free or draining
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.pop_value = out_pop_value;
  assign rsp.occupancy = out_occupancy;

  // Next pointers, RAM access and status for the incoming transaction
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = head;
    status_v   = ST_DONE;
    state_next = state;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
              if (full) begin
                status_v = ST_OVERFLOW;
              end else begin
                count_next = count + 1'b1;
                wr_en      = 1'b1;
                if (empty) begin
                  head_next = '0;
                  tail_next = '0;
                  wr_addr   = '0;
                end else if (req.func == FUNC_PUSH_FRONT) begin
                  head_next = step_down(head);
                  wr_addr   = head_next;
                end else begin
                  tail_next = step_up(tail);
                  wr_addr   = tail_next;
                end
              end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK: begin
              if (empty) begin
                status_v = ST_UNDERFLOW;
              end else begin
                count_next = count - 1'b1;
                rd_en      = 1'b1;
                state_next = S_READ;
                if (req.func == FUNC_POP_FRONT) begin
                  rd_addr   = head;
                  head_next = step_up(head);
                end else begin
                  rd_addr   = tail;
                  tail_next = step_down(tail);
                end
                // Last word gone: both ends return to slot 0
                if (count == CNT_W'(1)) begin
                  head_next = '0;
                  tail_next = '0;
                end
              end
            end
            default: begin
              status_v = ST_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      state <= S_IDLE;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      state <= state_next;
    end
  end

  // Response valid: set on completion, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_READ) begin
      out_valid <= 1'b1;
    end else if (accept && !rd_en) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Response payload; the popped word is loaded from the RAM read register in S_READ
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status    <= status_v;
      out_occupancy <= OCC_W'(count_next);
      out_pop_value <= '0;
    end else if (state == S_READ) begin
      out_pop_value <= rd_data;
    end
  end

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for circular_deque: directed and random deque operations,
// with a predictor of the store and a response checker on the result channel.
// Depends on cdq_pkg, the cdq_req_if / cdq_rsp_if interfaces and circular_deque.

module testbench;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT  = 700;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    func_t              func;
    logic signed [31:0] word;
    bit                 wait_drain;   // hold back until every result is in
  } deque_op_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] pop_value;
    logic [3:0]         occupancy;
  } deque_result_t;

  logic clk;
  logic rst;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Stimulus and expectations
  deque_op_t     pending_ops[$];
  deque_result_t expected_results[$];
  int unsigned   op_total;
  int unsigned   sent_total;
  int unsigned   error_total;

  // Shadow copy of the deque
  logic signed [31:0] shadow_words [DEPTH];
  int unsigned        front_idx;
  int unsigned        back_idx;
  int unsigned        held_words;

  // Sender and receiver pacing
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycle;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned stall_mode;
  int unsigned idle_cycles;
  deque_op_t   drv_op;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic queue_op(input func_t f, input logic signed [31:0] w, input bit drain);
    deque_op_t op;
    op.func       = f;
    op.word       = w;
    op.wait_drain = drain;
    pending_ops.push_back(op);
    op_total++;
  endtask

  // Apply one accepted operation to the shadow deque and queue its result
  task automatic predict_deque(input func_t f, input logic signed [31:0] w);
    deque_result_t r;
    r.status    = ST_DONE;
    r.pop_value = '0;
    if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) begin
      if (held_words == DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        if (held_words == 0) begin
          front_idx = 0;
          back_idx  = 0;
        end else if (f == FUNC_PUSH_FRONT) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
        end else begin
          back_idx = (back_idx == DEPTH - 1) ? 0 : back_idx + 1;
        end
        // on an empty deque both indices are zero, so either slot works
        shadow_words[(f == FUNC_PUSH_FRONT) ? front_idx : back_idx] = w;
        held_words++;
      end
    end else if (held_words == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      if (f == FUNC_POP_FRONT) begin
        r.pop_value = shadow_words[front_idx];
        front_idx   = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
      end else begin
        r.pop_value = shadow_words[back_idx];
        back_idx    = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
      end
      held_words--;
      if (held_words == 0) begin
        front_idx = 0;
        back_idx  = 0;
      end
    end
    r.occupancy = 4'(held_words);
    expected_results.push_back(r);
  endtask

  // Driver: offers queued operations in bursts, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_deque(req_ch.func, req_ch.push_value);
        sent_total++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() == 0 ||
                     (pending_ops[0].wait_drain && expected_results.size() != 0)) begin
          req_ch.valid <= 1'b0;
        end else begin
          drv_op = pending_ops.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.func       <= drv_op.func;
          req_ch.push_value <= drv_op.word;
          burst_left--;
          // end of burst: pick a gap (sometimes none) and the next burst length
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus long hold-offs to back the block up
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_cycle   = 0;
      hold_left  = 0;
      stall_left = 0;
      stall_mode = 0;
    end else begin
      rx_cycle++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rx_cycle == 400 || rx_cycle == 1300) begin
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 1) == 1);
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: compare each response transaction with the oldest expectation
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("response with no operation outstanding: status %0d pop_value %0d",
               rsp_ch.status, rsp_ch.pop_value);
        error_total++;
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
          error_total++;
        end
        if (rsp_ch.pop_value !== exp_r.pop_value) begin
          $error("pop_value: expected %0d, got %0d", exp_r.pop_value, rsp_ch.pop_value);
          error_total++;
        end
        if (rsp_ch.occupancy !== exp_r.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_r.occupancy, rsp_ch.occupancy);
          error_total++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    func_t              f;
    logic signed [31:0] w;
    int unsigned        seg_left;
    int unsigned        push_pct;

    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_PUSH_FRONT;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    rst               = 1'b1;
    op_total          = 0;
    sent_total        = 0;
    error_total       = 0;
    front_idx         = 0;
    back_idx          = 0;
    held_words        = 0;
    seg_left          = 0;
    push_pct          = 50;

    // Directed: underflow on empty, push into empty, last-word pop, front wrap,
    // fill to full, overflow on both ends, then drain past empty
    queue_op(FUNC_POP_FRONT,  32'sh12345678, 1'b0);
    queue_op(FUNC_POP_BACK,   -32'sd1,       1'b0);
    queue_op(FUNC_PUSH_FRONT, 32'sh7fffffff, 1'b0);
    queue_op(FUNC_POP_BACK,   32'sh0,        1'b0);
    queue_op(FUNC_PUSH_BACK,  32'sh80000000, 1'b0);
    queue_op(FUNC_PUSH_FRONT, -32'sd1,       1'b0);
    queue_op(FUNC_PUSH_FRONT, 32'sh0,        1'b0);
    queue_op(FUNC_PUSH_BACK,  32'sh55555555, 1'b0);
    queue_op(FUNC_PUSH_BACK,  32'shaaaaaaaa, 1'b0);
    queue_op(FUNC_PUSH_FRONT, 32'sh1,        1'b0);
    queue_op(FUNC_PUSH_BACK,  32'sh7fffffff, 1'b0);
    queue_op(FUNC_PUSH_FRONT, 32'sh80000000, 1'b0);
    queue_op(FUNC_PUSH_FRONT, 32'sh0f0f0f0f, 1'b0);
    queue_op(FUNC_PUSH_BACK,  32'shf0f0f0f0, 1'b0);
    queue_op(FUNC_POP_FRONT,  32'sh0,        1'b0);
    queue_op(FUNC_POP_BACK,   32'sh0,        1'b0);
    queue_op(FUNC_PUSH_BACK,  32'sh3c3c3c3c, 1'b0);
    for (int i = 0; i < 7; i++) begin
      queue_op((i % 2 == 0) ? FUNC_POP_FRONT : FUNC_POP_BACK, -32'sd1, 1'b0);
    end
    queue_op(FUNC_POP_FRONT, 32'sh0, 1'b0);

    // Random: segments that lean towards filling, draining or churning
    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      seg_left--;
      if ($urandom_range(1, 100) <= push_pct) begin
        f = ($urandom_range(0, 1) == 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end else begin
        f = ($urandom_range(0, 1) == 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      end
      w = $urandom();
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       w = 32'sh7fffffff;
          1:       w = 32'sh80000000;
          2:       w = '0;
          default: w = '1;
        endcase
      end
      queue_op(f, w, (n % 175) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transaction to go through and every result to arrive
    while (sent_total != op_total || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_total == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
